>>> hdl/wsenc_pkg.sv
// wsenc_pkg: shared types and constants for the masked frame encoder
// used by the front end, the job queue, the serializer and the top level
`timescale 1ns / 1ps

package wsenc_pkg;

   // field widths fixed by the frame format
   localparam int LEN_W  = 63;
   localparam int KEY_W  = 32;
   localparam int BYTE_W = 8;

   // header constants
   localparam logic [7:0]       MASK_BIT      = 8'h80;
   localparam logic [LEN_W-1:0] LEN_SHORT_MAX = 63'd125;
   localparam logic [LEN_W-1:0] LEN_MID_MAX   = 63'd65535;
   localparam logic [6:0]       LEN_MARK16    = 7'd126;
   localparam logic [6:0]       LEN_MARK64    = 7'd127;

   // input modes
   localparam logic MODE_START = 1'b0;
   localparam logic MODE_DATA  = 1'b1;

   // job kinds
   localparam logic JOB_HEADER = 1'b0;
   localparam logic JOB_DATA   = 1'b1;

   // length encodings
   localparam logic [1:0] CLASS_SHORT = 2'd0;
   localparam logic [1:0] CLASS_MID   = 2'd1;
   localparam logic [1:0] CLASS_LONG  = 2'd2;

   // last byte index of a header for each length encoding
   localparam logic [3:0] LAST_SHORT = 4'd5;
   localparam logic [3:0] LAST_MID   = 4'd7;
   localparam logic [3:0] LAST_LONG  = 4'd13;

   // one job handed from the front end to the serializer
   typedef struct packed {
      logic              kind;       // header or masked data word
      logic [1:0]        len_class;  // header length encoding
      logic [7:0]        first_byte; // header byte 0, or the masked data word
      logic              frame_end;  // data: frame ends here; header: empty frame
      logic [LEN_W-1:0]  length;
      logic [KEY_W-1:0]  key;
   } job_type;

   // pick key byte idx, bits 31:24 first
   function automatic logic [7:0] key_byte(input logic [KEY_W-1:0] key,
                                           input logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = key[31:24];
         2'd1:    b = key[23:16];
         2'd2:    b = key[15:8];
         default: b = key[7:0];
      endcase
      return b;
   endfunction

endpackage

>>> hdl/websocket_masked_frame_encoder.sv
// Masked client frame encoder. A frame-start word (mode 0) produces the
// header: 6 wire words for payloads up to 125, 8 up to 65535 and 14 beyond,
// the four key words coming last; each payload word (mode 1) of an open frame
// produces one masked wire word, and payload words with no open frame produce
// nothing. The front end takes one input word per cycle while the job queue
// (QUEUE_DEPTH entries, at least 2) has room; the serializer sends one wire
// word per cycle while the output is ready, so payload streams at one word per
// cycle when nothing stalls, and the queue absorbs the longer headers. An
// accepted word passes through the queue, the job and the output registers.
// depends on wsenc_pkg, wsenc_front, wsenc_queue and wsenc_back
`timescale 1ns / 1ps

module websocket_masked_frame_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic                         req_fin,
   input  logic [3:0]                   req_opcode,
   input  logic [wsenc_pkg::LEN_W-1:0]  req_payload_length,
   input  logic [wsenc_pkg::KEY_W-1:0]  req_mask_key,
   input  logic [wsenc_pkg::BYTE_W-1:0] req_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [wsenc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                         rsp_last,
   output logic                         rsp_frame_end
);

   logic               push;
   wsenc_pkg::job_type push_job;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   wsenc_pkg::job_type head_job;

   // front end: classify, track frame, mask data
   wsenc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_fin            (req_fin),
      .req_opcode         (req_opcode),
      .req_payload_length (req_payload_length),
      .req_mask_key       (req_mask_key),
      .req_data_byte      (req_data_byte),
      .queue_full         (queue_full),
      .push               (push),
      .push_job           (push_job)
   );

   // job queue
   wsenc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // serializer
   wsenc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

>>> hdl/wsenc_front.sv
// wsenc_front: accepts input words, tracks the open frame and masks data words
// depends on wsenc_pkg; pushes jobs into wsenc_queue
`timescale 1ns / 1ps

module wsenc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_mode,
   input  logic                              req_fin,
   input  logic [3:0]                        req_opcode,
   input  logic [wsenc_pkg::LEN_W-1:0]       req_payload_length,
   input  logic [wsenc_pkg::KEY_W-1:0]       req_mask_key,
   input  logic [wsenc_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                              queue_full,
   output logic                              push,
   output wsenc_pkg::job_type                push_job
);

   logic [wsenc_pkg::KEY_W-1:0] key_ff, key_in;
   logic [1:0]                  key_index_ff, key_index_in;
   logic [wsenc_pkg::LEN_W-1:0] bytes_left_ff, bytes_left_in;
   logic                        frame_open_ff, frame_open_in;

   logic accept;
   logic data_end;
   logic start_empty;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // classify the word and build its job
   always_comb begin
      start_empty = (req_payload_length == '0);
      data_end    = (bytes_left_ff <= wsenc_pkg::LEN_W'(1));

      push_job.kind       = wsenc_pkg::JOB_HEADER;
      push_job.len_class  = wsenc_pkg::CLASS_LONG;
      push_job.first_byte = {req_fin, 3'b000, req_opcode};
      push_job.frame_end  = start_empty;
      push_job.length     = req_payload_length;
      push_job.key        = req_mask_key;
      if (req_payload_length <= wsenc_pkg::LEN_SHORT_MAX) begin
         push_job.len_class = wsenc_pkg::CLASS_SHORT;
      end else if (req_payload_length <= wsenc_pkg::LEN_MID_MAX) begin
         push_job.len_class = wsenc_pkg::CLASS_MID;
      end
      if (req_mode == wsenc_pkg::MODE_DATA) begin
         push_job.kind       = wsenc_pkg::JOB_DATA;
         push_job.first_byte = req_data_byte ^ wsenc_pkg::key_byte(key_ff, key_index_ff);
         push_job.frame_end  = data_end;
      end

      push = accept && ((req_mode == wsenc_pkg::MODE_START) || frame_open_ff);
   end

   // frame state update
   always_comb begin
      key_in        = key_ff;
      key_index_in  = key_index_ff;
      bytes_left_in = bytes_left_ff;
      frame_open_in = frame_open_ff;
      if (accept && req_mode == wsenc_pkg::MODE_START) begin
         key_in        = req_mask_key;
         key_index_in  = 2'd0;
         bytes_left_in = req_payload_length;
         frame_open_in = !start_empty;
      end else if (accept && frame_open_ff) begin
         key_index_in  = key_index_ff + 2'd1;
         bytes_left_in = data_end ? '0 : bytes_left_ff - wsenc_pkg::LEN_W'(1);
         frame_open_in = !data_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         key_index_ff  <= '0;
         bytes_left_ff <= '0;
         frame_open_ff <= 1'b0;
      end else begin
         key_ff        <= key_in;
         key_index_ff  <= key_index_in;
         bytes_left_ff <= bytes_left_in;
         frame_open_ff <= frame_open_in;
      end
   end

endmodule

>>> hdl/wsenc_queue.sv
// wsenc_queue: small job queue between the front end and the serializer
// depends on wsenc_pkg for the job type; DEPTH must be at least 2
`timescale 1ns / 1ps

module wsenc_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsenc_pkg::job_type push_job,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output wsenc_pkg::job_type head_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   wsenc_pkg::job_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hdl/wsenc_back.sv
// wsenc_back: serializes jobs into wire words behind an output register
// depends on wsenc_pkg; takes jobs from wsenc_queue
`timescale 1ns / 1ps

module wsenc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  wsenc_pkg::job_type           head_job,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [wsenc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic                         rsp_last,
   output logic                         rsp_frame_end
);

   wsenc_pkg::job_type job_ff, job_in;
   logic       job_valid_ff, job_valid_in;
   logic [3:0] idx_ff, idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       rsp_end_ff, rsp_end_in;

   logic [3:0]  last_idx;
   logic [3:0]  key_start;
   logic [3:0]  key_off;
   logic        is_last;
   logic        advance;
   logic [7:0]  cur_byte;
   logic [63:0] len64;

   // pick the current wire word
   always_comb begin
      len64 = {1'b0, job_ff.length};
      case (job_ff.len_class)
         wsenc_pkg::CLASS_SHORT: last_idx = wsenc_pkg::LAST_SHORT;
         wsenc_pkg::CLASS_MID:   last_idx = wsenc_pkg::LAST_MID;
         default:                last_idx = wsenc_pkg::LAST_LONG;
      endcase
      key_start = last_idx - 4'd3;
      key_off   = idx_ff - key_start;
      is_last   = (job_ff.kind == wsenc_pkg::JOB_DATA) || (idx_ff == last_idx);

      cur_byte = job_ff.first_byte;
      if (job_ff.kind == wsenc_pkg::JOB_HEADER) begin
         if (idx_ff >= key_start) begin
            cur_byte = wsenc_pkg::key_byte(job_ff.key, key_off[1:0]);
         end else if (idx_ff == 4'd1) begin
            case (job_ff.len_class)
               wsenc_pkg::CLASS_SHORT: cur_byte = wsenc_pkg::MASK_BIT | {1'b0, len64[6:0]};
               wsenc_pkg::CLASS_MID:   cur_byte = wsenc_pkg::MASK_BIT | {1'b0, wsenc_pkg::LEN_MARK16};
               default:                cur_byte = wsenc_pkg::MASK_BIT | {1'b0, wsenc_pkg::LEN_MARK64};
            endcase
         end else if (idx_ff != 4'd0) begin
            if (job_ff.len_class == wsenc_pkg::CLASS_MID) begin
               cur_byte = (idx_ff == 4'd2) ? len64[15:8] : len64[7:0];
            end else begin
               case (idx_ff)
                  4'd2:    cur_byte = len64[63:56];
                  4'd3:    cur_byte = len64[55:48];
                  4'd4:    cur_byte = len64[47:40];
                  4'd5:    cur_byte = len64[39:32];
                  4'd6:    cur_byte = len64[31:24];
                  4'd7:    cur_byte = len64[23:16];
                  4'd8:    cur_byte = len64[15:8];
                  default: cur_byte = len64[7:0];
               endcase
            end
         end
      end
   end

   // job sequencing and output register
   always_comb begin
      advance = job_valid_ff && (!rsp_valid_ff || rsp_ready);
      pop     = head_valid && (!job_valid_ff || (advance && is_last));

      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         job_in       = head_job;
         job_valid_in = 1'b1;
         idx_in       = 4'd0;
      end else if (advance && is_last) begin
         job_valid_in = 1'b0;
      end else if (advance) begin
         idx_in = idx_ff + 4'd1;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_end_in   = rsp_end_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = cur_byte;
         rsp_last_in  = is_last;
         rsp_end_in   = is_last && job_ff.frame_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_frame_end = rsp_end_ff;

endmodule

>>> bench/tb.sv
// tb: self-checking bench for the masked client frame encoder
// predicts wire bytes from each accepted word and checks them in order
// depends on wsenc_pkg and websocket_masked_frame_encoder
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic                         mode;
      logic                         fin;
      logic [3:0]                   opcode;
      logic [wsenc_pkg::LEN_W-1:0]  length;
      logic [wsenc_pkg::KEY_W-1:0]  key;
      logic [wsenc_pkg::BYTE_W-1:0] data;
   } req_word_type;

   typedef struct {
      logic [wsenc_pkg::BYTE_W-1:0] wire_byte;
      logic                         last;
      logic                         frame_end;
   } wire_word_type;

   // tracks the frame state and the wire bytes still owed by the encoder
   class frame_wire_tracker;
      logic [wsenc_pkg::KEY_W-1:0] open_key;
      logic [1:0]                  key_pos;
      logic [wsenc_pkg::LEN_W-1:0] remaining;
      bit                          frame_open;
      wire_word_type               wire_bytes_due[$];
      int                          errors;
      int                          wire_checked;
      int                          n_short, n_mid, n_long, n_payload, n_stray;

      function new();
         open_key   = '0;
         key_pos    = '0;
         remaining  = '0;
         frame_open = 1'b0;
      endfunction

      function logic [7:0] key_lane(logic [wsenc_pkg::KEY_W-1:0] key, logic [1:0] idx);
         return 8'(key >> (8 * (3 - int'(idx))));
      endfunction

      function void add_wire(logic [7:0] b, logic lst, logic fe);
         wire_word_type w;
         w.wire_byte = b;
         w.last      = lst;
         w.frame_end = fe;
         wire_bytes_due.push_back(w);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) $display("%s", msg);
      endfunction

      // work out the wire bytes caused by one accepted word
      function void take_word(req_word_type w);
         logic [wsenc_pkg::LEN_W-1:0] len;
         logic                        done;
         int                          s;
         if (w.mode == wsenc_pkg::MODE_START) begin
            len = w.length;
            add_wire({w.fin, 3'b000, w.opcode}, 1'b0, 1'b0);
            // length field, shortest encoding that fits
            if (len <= wsenc_pkg::LEN_SHORT_MAX) begin
               add_wire(wsenc_pkg::MASK_BIT | 8'(len), 1'b0, 1'b0);
               n_short++;
            end else if (len <= wsenc_pkg::LEN_MID_MAX) begin
               add_wire(wsenc_pkg::MASK_BIT | {1'b0, wsenc_pkg::LEN_MARK16}, 1'b0, 1'b0);
               add_wire(len[15:8], 1'b0, 1'b0);
               add_wire(len[7:0], 1'b0, 1'b0);
               n_mid++;
            end else begin
               add_wire(wsenc_pkg::MASK_BIT | {1'b0, wsenc_pkg::LEN_MARK64}, 1'b0, 1'b0);
               for (s = 56; s >= 0; s -= 8)
                  add_wire(8'({1'b0, len} >> s), 1'b0, 1'b0);
               n_long++;
            end
            // key bytes, empty frame ends on the last one
            for (s = 0; s < 4; s++)
               add_wire(key_lane(w.key, 2'(s)), s == 3, (s == 3) && (len == 0));
            open_key   = w.key;
            key_pos    = '0;
            remaining  = len;
            frame_open = (len != 0);
         end else if (frame_open) begin
            done = (remaining <= 1);
            add_wire(w.data ^ key_lane(open_key, key_pos), 1'b1, done);
            key_pos++;
            remaining = done ? '0 : remaining - 1'b1;
            if (done) frame_open = 1'b0;
            n_payload++;
         end else begin
            n_stray++;
         end
      endfunction

      // compare one wire byte with the oldest one owed
      function void check_wire(wire_word_type got);
         wire_word_type exp;
         wire_checked++;
         if (wire_bytes_due.size() == 0) begin
            flag($sformatf("unexpected wire byte %02h last %0b frame_end %0b",
                           got.wire_byte, got.last, got.frame_end));
            return;
         end
         exp = wire_bytes_due.pop_front();
         if (got.wire_byte !== exp.wire_byte || got.last !== exp.last ||
             got.frame_end !== exp.frame_end)
            flag($sformatf({"wire byte %0d: expected %02h/%0b/%0b ",
                            "got %02h/%0b/%0b (byte/last/frame_end)"},
                           wire_checked, exp.wire_byte, exp.last, exp.frame_end,
                           got.wire_byte, got.last, got.frame_end));
      endfunction
   endclass

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic                         req_mode = wsenc_pkg::MODE_DATA;
   logic                         req_fin = 1'b0;
   logic [3:0]                   req_opcode = '0;
   logic [wsenc_pkg::LEN_W-1:0]  req_payload_length = '0;
   logic [wsenc_pkg::KEY_W-1:0]  req_mask_key = '0;
   logic [wsenc_pkg::BYTE_W-1:0] req_data_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [wsenc_pkg::BYTE_W-1:0] rsp_out_byte;
   logic                         rsp_last;
   logic                         rsp_frame_end;

   frame_wire_tracker tracker;
   bit                calm = 1'b0;
   int                words_sent = 0;
   int                stall_left = 0;

   websocket_masked_frame_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_fin            (req_fin),
      .req_opcode         (req_opcode),
      .req_payload_length (req_payload_length),
      .req_mask_key       (req_mask_key),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_last           (rsp_last),
      .rsp_frame_end      (rsp_frame_end)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // output side: check accepted words, stall in random bursts
   always @(posedge clock) begin
      wire_word_type got;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.wire_byte = rsp_out_byte;
            got.last      = rsp_last;
            got.frame_end = rsp_frame_end;
            tracker.check_wire(got);
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic logic [wsenc_pkg::LEN_W-1:0] rand_len63();
      return wsenc_pkg::LEN_W'({$urandom, $urandom});
   endfunction

   // drive one word and wait for it to be taken
   task automatic push_word(input req_word_type w);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= w.mode;
      req_fin            <= w.fin;
      req_opcode         <= w.opcode;
      req_payload_length <= w.length;
      req_mask_key       <= w.key;
      req_data_byte      <= w.data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_word(w);
      words_sent++;
   endtask

   task automatic send_start(input logic fin, input logic [3:0] op,
                             input logic [wsenc_pkg::LEN_W-1:0] len,
                             input logic [wsenc_pkg::KEY_W-1:0] key);
      req_word_type w;
      w.mode   = wsenc_pkg::MODE_START;
      w.fin    = fin;
      w.opcode = op;
      w.length = len;
      w.key    = key;
      w.data   = 8'($urandom);
      push_word(w);
   endtask

   // payload word, header fields filled with junk
   task automatic send_data(input logic [wsenc_pkg::BYTE_W-1:0] d);
      req_word_type w;
      w.mode   = wsenc_pkg::MODE_DATA;
      w.fin    = 1'($urandom);
      w.opcode = 4'($urandom);
      w.length = rand_len63();
      w.key    = $urandom;
      w.data   = d;
      push_word(w);
   endtask

   // frame start with random header fields, then n payload words
   task automatic send_frame(input logic [wsenc_pkg::LEN_W-1:0] len, input int n);
      int i;
      send_start(1'($urandom), 4'($urandom), len, $urandom);
      for (i = 0; i < n; i++) send_data(8'($urandom));
   endtask

   initial begin
      int                          pick;
      int                          n;
      logic [wsenc_pkg::LEN_W-1:0] len;
      int                          leftover;
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: stray word, empty frame, length boundaries, abandon, wrap
      send_data(8'h5A);
      send_start(1'b1, 4'h0, '0, 32'hFFFF_FFFF);
      send_start(1'b0, 4'hF, 63'd1, 32'h0000_0000);
      send_data(8'hFF);
      send_start(1'b1, 4'h1, wsenc_pkg::LEN_SHORT_MAX, $urandom);
      send_data(8'h00);
      send_data(8'hFF);
      send_start(1'b1, 4'h2, 63'd126, 32'h8040_2010);
      send_data(8'h02);
      send_start(1'b0, 4'h8, wsenc_pkg::LEN_MID_MAX, $urandom);
      send_data(8'h81);
      send_start(1'b1, 4'h9, 63'd65536, $urandom);
      send_start(1'b0, 4'hA, '1, $urandom);
      send_data(8'h7E);
      send_start(1'b1, 4'h1, 63'd5, 32'hA5A5_5A5A);
      repeat (5) send_data(8'($urandom));
      send_data(8'h33);

      // random: mostly complete small frames, some long headers and noise
      while (words_sent < 360) begin
         if (words_sent >= 320) calm = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_data(8'($urandom));
         end else if (pick < 60) begin
            len = 63'($urandom_range(0, 12));
            n   = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int'(len)) : int'(len);
            send_frame(len, n);
         end else if (pick < 65) begin
            len = 63'($urandom_range(13, 125));
            send_frame(len, int'(len));
         end else if (pick < 80) begin
            case ($urandom_range(0, 3))
               0:       len = 63'd126;
               1:       len = wsenc_pkg::LEN_MID_MAX;
               default: len = 63'($urandom_range(127, 65534));
            endcase
            send_frame(len, $urandom_range(0, 4));
         end else begin
            len = rand_len63();
            if (len <= wsenc_pkg::LEN_MID_MAX) len = len + 63'd65536;
            send_frame(len, $urandom_range(0, 4));
         end
      end

      // drain, then keep watching the output for anything extra to show up
      req_valid <= 1'b0;
      while (tracker.wire_bytes_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      leftover = tracker.wire_bytes_due.size();
      if (leftover != 0) $display("%0d wire bytes never arrived", leftover);
      $display("covered %0d frames (%0d short, %0d 16-bit, %0d 64-bit lengths),",
               tracker.n_short + tracker.n_mid + tracker.n_long,
               tracker.n_short, tracker.n_mid, tracker.n_long);
      $display("%0d payload words, %0d stray words; %0d wire bytes checked, %0d errors",
               tracker.n_payload, tracker.n_stray, tracker.wire_checked, tracker.errors);
      if (tracker.errors == 0 && leftover == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
